### sv/sync_frame_receiver_crc16_defines.svh
// Assertion macros for the sync frame receiver
// Used by the top level only; no other dependencies
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define SFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("sfr assertion failed");
// same, with a caller supplied message
`define SFR_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error(msg);
`else
`define SFR_ASSERT(lbl, prop)
`define SFR_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

### sv/sfr_pkg.sv
// Shared constants, types and the crc byte update for the sync frame receiver
// No dependencies
package sfr_pkg;

    localparam int PAYLOAD_WORDS = 14;
    // word address width, at least one bit
    localparam int WA_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int IDX_W = 5;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(PAYLOAD_WORDS - 1);

    localparam logic [7:0] SYNC_A = 8'h3E;
    localparam logic [7:0] SYNC_B = 8'h2A;
    localparam logic [15:0] CRC_INIT = 16'h00FF;

    // controller to datapath
    typedef struct packed {
        logic desc_load;
        logic pay_take;
        logic crc_lo_load;
        logic err_load;
        logic emit_clr;
        logic rd_word;
        logic emit_inc;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sync_a;
        logic sync_b;
        logic word_end;
        logic crc_match;
        logic out_last;
    } t_status;

    // reflected ccitt byte update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        logic [15:0] r;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        r = {t, crc[15:8]};
        r = r ^ {12'b0, t[7:4]};
        r = r ^ {5'b0, t, 3'b000};
        return r;
    endfunction

endpackage

### sv/sfr_ctrl.sv
// Frame phase state machine for the sync frame receiver
// Depends on sfr_pkg for the command and status structs
module sfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    output logic           o_rx_ready,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    input  sfr_pkg::t_status i_status,
    output sfr_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_HUNT0 = 4'd0;
    localparam logic [3:0] S_HUNT1 = 4'd1;
    localparam logic [3:0] S_HUNT2 = 4'd2;
    localparam logic [3:0] S_DESC  = 4'd3;
    localparam logic [3:0] S_PAY   = 4'd4;
    localparam logic [3:0] S_CRCLO = 4'd5;
    localparam logic [3:0] S_CRCHI = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       acc;

    assign o_rx_ready  = (r_state < S_RD);
    assign o_res_valid = (r_state == S_WAIT);
    assign acc         = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT0: begin
                if (acc) n_state = i_status.sync_a ? S_HUNT1 : S_HUNT0;
            end
            S_HUNT1: begin
                if (acc) n_state = i_status.sync_b ? S_HUNT2 : S_HUNT0;
            end
            S_HUNT2: begin
                if (acc) n_state = i_status.sync_a ? S_DESC : S_HUNT0;
            end
            S_DESC: begin
                if (acc) begin
                    o_cmd.desc_load = 1'b1;
                    n_state = S_PAY;
                end
            end
            S_PAY: begin
                if (acc) begin
                    o_cmd.pay_take = 1'b1;
                    if (i_status.word_end) n_state = S_CRCLO;
                end
            end
            S_CRCLO: begin
                if (acc) begin
                    o_cmd.crc_lo_load = 1'b1;
                    n_state = S_CRCHI;
                end
            end
            S_CRCHI: begin
                if (acc) begin
                    if (i_status.crc_match) begin
                        o_cmd.emit_clr = 1'b1;
                        n_state = S_RD;
                    end else begin
                        o_cmd.err_load = 1'b1;
                        n_state = S_WAIT;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_word = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_res_ready) begin
                    if (i_status.out_last) begin
                        n_state = S_HUNT0;
                    end else begin
                        o_cmd.emit_inc = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HUNT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/sfr_datapath.sv
// Datapath of the sync frame receiver: crc, payload memory, counters, result register
// Depends on sfr_pkg for constants, structs and the crc update
module sfr_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_rx_byte,
    input  sfr_pkg::t_cmd             i_cmd,
    output sfr_pkg::t_status          o_status,
    output logic signed [15:0]        o_payload_word,
    output logic [sfr_pkg::IDX_W-1:0] o_word_index,
    output logic [7:0]                o_frame_descriptor,
    output logic                      o_crc_ok,
    output logic                      o_last
);

    logic [15:0]              r_mem [sfr_pkg::PAYLOAD_WORDS];
    logic [15:0]              r_crc;
    logic [7:0]               r_desc;
    logic [7:0]               r_crc_lo;
    logic [7:0]               r_lo_byte;
    logic                     r_hi;
    logic [sfr_pkg::WA_W-1:0] r_wcnt;
    logic [sfr_pkg::WA_W-1:0] r_emit;
    logic [15:0]              r_out_word;
    logic [sfr_pkg::WA_W-1:0] r_out_idx;
    logic                     r_out_ok;
    logic                     r_out_last;

    assign o_status.sync_a    = (i_rx_byte == sfr_pkg::SYNC_A);
    assign o_status.sync_b    = (i_rx_byte == sfr_pkg::SYNC_B);
    assign o_status.word_end  = r_hi && (r_wcnt == sfr_pkg::LAST_WORD);
    assign o_status.crc_match = ({i_rx_byte, r_crc_lo} == r_crc);
    assign o_status.out_last  = r_out_last;

    assign o_payload_word     = r_out_word;
    assign o_word_index       = sfr_pkg::IDX_W'(r_out_idx);
    assign o_frame_descriptor = r_desc;
    assign o_crc_ok           = r_out_ok;
    assign o_last             = r_out_last;

    // payload memory: one word written per byte pair, read into the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_take && r_hi) begin
            r_mem[r_wcnt] <= {i_rx_byte, r_lo_byte};
        end
        if (i_cmd.rd_word) begin
            r_out_word <= r_mem[r_emit];
        end else if (i_cmd.err_load) begin
            r_out_word <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_take && !r_hi) r_lo_byte <= i_rx_byte;
        if (i_cmd.crc_lo_load) r_crc_lo <= i_rx_byte;
        if (i_cmd.rd_word) begin
            r_out_idx  <= r_emit;
            r_out_ok   <= 1'b1;
            r_out_last <= (r_emit == sfr_pkg::LAST_WORD);
        end else if (i_cmd.err_load) begin
            r_out_idx  <= '0;
            r_out_ok   <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= sfr_pkg::CRC_INIT;
            r_desc <= '0;
            r_hi   <= 1'b0;
            r_wcnt <= '0;
            r_emit <= '0;
        end else begin
            if (i_cmd.desc_load) begin
                r_desc <= i_rx_byte;
                r_crc  <= sfr_pkg::CRC_INIT;
                r_hi   <= 1'b0;
                r_wcnt <= '0;
            end else if (i_cmd.pay_take) begin
                r_crc <= sfr_pkg::crc_byte(r_crc, i_rx_byte);
                r_hi  <= !r_hi;
                if (r_hi) r_wcnt <= r_wcnt + 1'b1;
            end
            if (i_cmd.emit_clr) begin
                r_emit <= '0;
            end else if (i_cmd.emit_inc) begin
                r_emit <= r_emit + 1'b1;
            end
        end
    end

endmodule

### sv/sync_frame_receiver_crc16.sv
// Sync frame receiver: hunts for the '>' '*' '>' header, takes a descriptor byte,
// sfr_pkg::PAYLOAD_WORDS little-endian words and a little-endian crc-16 (reflected
// ccitt, init 0x00ff, over the payload bytes). A wrong sync byte drops back to the
// hunt without looking at that byte again. Received bytes are taken one per cycle
// while no frame is being delivered. After the last crc byte the receiver stops
// taking bytes while it delivers the frame: on a good crc one result per payload
// word, each read from the payload memory into the result register, with last
// on the final word; on a bad crc a single result with crc_ok low, a zero word
// and last set. Input ready returns in the cycle after the last result is taken.
// Depends on sfr_pkg, sfr_ctrl, sfr_datapath and the assertion macro header
`include "sync_frame_receiver_crc16_defines.svh"

module sync_frame_receiver_crc16 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [7:0]                i_rx_byte,
    input  logic                      i_rx_valid,
    output logic                      o_rx_ready,
    output logic signed [15:0]        o_payload_word,
    output logic [sfr_pkg::IDX_W-1:0] o_word_index,
    output logic [7:0]                o_frame_descriptor,
    output logic                      o_crc_ok,
    output logic                      o_last,
    output logic                      o_res_valid,
    input  logic                      i_res_ready
);

    sfr_pkg::t_cmd    cmd;
    sfr_pkg::t_status status;

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sfr_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_byte          (i_rx_byte),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_payload_word     (o_payload_word),
        .o_word_index       (o_word_index),
        .o_frame_descriptor (o_frame_descriptor),
        .o_crc_ok           (o_crc_ok),
        .o_last             (o_last)
    );

    // reception and delivery never overlap
    `SFR_ASSERT(a_no_overlap, !(o_res_valid && o_rx_ready))
    // final result taken means the hunt restarts next cycle
    `SFR_ASSERT_MSG(a_hunt_after_last, o_res_valid && i_res_ready && o_last |=> o_rx_ready, "no hunt restart after last result")
    // an error result is a lone zero word
    `SFR_ASSERT_MSG(a_err_result, o_res_valid && !o_crc_ok |-> o_last && o_payload_word == 16'sd0 && o_word_index == '0, "malformed crc error result")

endmodule

### test/tb_sync_frame_receiver_crc16.sv
// Self-checking testbench for the sync frame receiver with crc-16 check
// Depends on sfr_pkg and the sync_frame_receiver_crc16 top level
`timescale 1ns / 100ps

module tb_sync_frame_receiver_crc16;

    localparam int PW          = sfr_pkg::PAYLOAD_WORDS;
    localparam int NBYTES      = 2 * PW;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 4 * PW + 10;
    localparam int LONG_HOLD   = 150;
    localparam int RAND_BYTES  = 130;

    // receive phases of the deframer
    typedef enum logic [2:0] {
        PH_SYNC_A, PH_SYNC_B, PH_SYNC_C, PH_DESC, PH_DATA, PH_CRC_LO, PH_CRC_HI
    } t_rx_phase;

    typedef struct {
        logic [7:0] b;
        bit         drain;
    } t_rx_item;

    typedef struct {
        logic signed [15:0]        word;
        logic [sfr_pkg::IDX_W-1:0] index;
        logic [7:0]                desc;
        logic                      ok;
        logic                      last;
    } t_frame_word;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic [7:0]                i_rx_byte = 8'h00;
    logic                      i_rx_valid = 1'b0;
    logic                      o_rx_ready;
    logic signed [15:0]        o_payload_word;
    logic [sfr_pkg::IDX_W-1:0] o_word_index;
    logic [7:0]                o_frame_descriptor;
    logic                      o_crc_ok;
    logic                      o_last;
    logic                      o_res_valid;
    logic                      i_res_ready = 1'b0;

    t_rx_item    rx_pending[$];
    t_frame_word frame_words[$];

    // deframer state as the testbench tracks it
    t_rx_phase   rx_phase = PH_SYNC_A;
    int          data_count = 0;
    logic [15:0] run_crc = sfr_pkg::CRC_INIT;
    logic [7:0]  data_store [NBYTES];
    logic [7:0]  held_desc = 8'h00;
    logic [7:0]  held_crc_lo = 8'h00;

    int err_count = 0;
    int rx_taken = 0;
    int res_taken = 0;
    int src_wait = 0;
    int sink_wait = 0;
    int idle_cycles = 0;

    sync_frame_receiver_crc16 i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_byte          (i_rx_byte),
        .i_rx_valid         (i_rx_valid),
        .o_rx_ready         (o_rx_ready),
        .o_payload_word     (o_payload_word),
        .o_word_index       (o_word_index),
        .o_frame_descriptor (o_frame_descriptor),
        .o_crc_ok           (o_crc_ok),
        .o_last             (o_last),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bitwise form of the reflected ccitt update, polynomial 0x8408
    function automatic logic [15:0] ccitt_refl_step(input logic [15:0] acc,
                                                    input logic [7:0] d);
        logic [15:0] c;
        c = acc ^ {8'h00, d};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_count++;
    endtask

    // advance the tracked deframer by one byte, queue any frame words it releases
    task automatic track_rx_byte(input logic [7:0] b);
        t_frame_word fw;
        case (rx_phase)
            PH_SYNC_B: rx_phase = (b == sfr_pkg::SYNC_B) ? PH_SYNC_C : PH_SYNC_A;
            PH_SYNC_C: rx_phase = (b == sfr_pkg::SYNC_A) ? PH_DESC : PH_SYNC_A;
            PH_DESC: begin
                held_desc = b;
                data_count = 0;
                run_crc = sfr_pkg::CRC_INIT;
                rx_phase = PH_DATA;
            end
            PH_DATA: begin
                data_store[data_count] = b;
                run_crc = ccitt_refl_step(run_crc, b);
                data_count++;
                if (data_count >= NBYTES)
                    rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                held_crc_lo = b;
                rx_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                if ({b, held_crc_lo} == run_crc) begin
                    for (int k = 0; k < PW; k++) begin
                        fw.word  = {data_store[2*k+1], data_store[2*k]};
                        fw.index = sfr_pkg::IDX_W'(k);
                        fw.desc  = held_desc;
                        fw.ok    = 1'b1;
                        fw.last  = (k == PW - 1);
                        frame_words.push_back(fw);
                    end
                end else begin
                    fw.word  = '0;
                    fw.index = '0;
                    fw.desc  = held_desc;
                    fw.ok    = 1'b0;
                    fw.last  = 1'b1;
                    frame_words.push_back(fw);
                end
                rx_phase = PH_SYNC_A;
                data_count = 0;
            end
            default: rx_phase = (b == sfr_pkg::SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
        endcase
    endtask

    // sender: one byte per transaction, random gaps, optional wait for an empty pipe
    always @(posedge i_clk) begin : rx_driver
        t_rx_item item;
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
            src_wait = 0;
        end else begin
            if (i_rx_valid && o_rx_ready) begin
                track_rx_byte(i_rx_byte);
                rx_taken++;
                src_wait = ((rx_taken / 48) % 3 == 2) ? 0 : $urandom_range(0, 3);
            end else if (!i_rx_valid && src_wait > 0) begin
                src_wait--;
            end
            if (!i_rx_valid || o_rx_ready) begin
                if (src_wait == 0 && rx_pending.size() != 0 &&
                    !(rx_pending[0].drain && frame_words.size() != 0)) begin
                    item = rx_pending.pop_front();
                    i_rx_byte  <= item.b;
                    i_rx_valid <= 1'b1;
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transaction against the oldest expected word
    always @(posedge i_clk) begin : res_monitor
        t_frame_word want;
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                if (frame_words.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              res_taken));
                end else begin
                    want = frame_words.pop_front();
                    if (o_payload_word !== want.word)
                        report_mismatch($sformatf("result %0d payload_word %0d, want %0d",
                                                  res_taken, o_payload_word, want.word));
                    if (o_word_index !== want.index)
                        report_mismatch($sformatf("result %0d word_index %0d, want %0d",
                                                  res_taken, o_word_index, want.index));
                    if (o_frame_descriptor !== want.desc)
                        report_mismatch($sformatf("result %0d descriptor %h, want %h",
                                                  res_taken, o_frame_descriptor, want.desc));
                    if (o_crc_ok !== want.ok)
                        report_mismatch($sformatf("result %0d crc_ok %b, want %b",
                                                  res_taken, o_crc_ok, want.ok));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("result %0d last %b, want %b",
                                                  res_taken, o_last, want.last));
                end
                res_taken++;
                // one long hold mid-frame so the block backs up onto its input
                if (res_taken == 20)
                    sink_wait = LONG_HOLD;
                else
                    sink_wait = ((res_taken / 30) % 3 == 1) ? 0 : $urandom_range(0, 3);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            i_res_ready <= (sink_wait == 0);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_sync_frame_receiver_crc16: errors");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit drain = 1'b0);
        t_rx_item it;
        it.b = b;
        it.drain = drain;
        rx_pending.push_back(it);
    endtask

    // sync, descriptor, payload and crc; a bad crc has one bit flipped
    task automatic queue_frame(input logic [7:0] desc, input logic [7:0] body [NBYTES],
                               input bit bad_crc, input bit drain);
        logic [15:0] crc;
        crc = sfr_pkg::CRC_INIT;
        queue_byte(sfr_pkg::SYNC_A, drain);
        queue_byte(sfr_pkg::SYNC_B);
        queue_byte(sfr_pkg::SYNC_A);
        queue_byte(desc);
        for (int i = 0; i < NBYTES; i++) begin
            queue_byte(body[i]);
            crc = ccitt_refl_step(crc, body[i]);
        end
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        queue_byte(crc[7:0]);
        queue_byte(crc[15:8]);
    endtask

    function automatic logic [7:0] pick_data_byte();
        logic [7:0] corner [6] = '{8'h00, 8'hFF, 8'h3E, 8'h2A, 8'h7F, 8'h80};
        return ($urandom_range(0, 3) == 0) ? corner[$urandom_range(0, 5)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] not_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(0, 254));
        return (b >= avoid) ? b + 8'd1 : b;
    endfunction

    initial begin : stimulus
        logic [7:0] body [NBYTES];
        logic [7:0] corner [12];
        int         built;
        int         est_results;
        int         frames;
        int         pick;
        int         cut;

        corner = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00,
                   8'h80, 8'h3E, 8'h2A, 8'h3E, 8'h3E};

        // a second '>' while waiting for '*' is dropped, not taken as a new start
        queue_byte(sfr_pkg::SYNC_A);
        queue_byte(sfr_pkg::SYNC_A);
        queue_byte(sfr_pkg::SYNC_B);
        queue_byte(sfr_pkg::SYNC_A);
        queue_byte(sfr_pkg::SYNC_A);
        // wrong third sync byte
        queue_byte(sfr_pkg::SYNC_A);
        queue_byte(sfr_pkg::SYNC_B);
        queue_byte(8'h00);

        // good frame: extreme words and sync characters as data
        for (int i = 0; i < NBYTES; i++)
            body[i] = (i < 12) ? corner[i] : 8'($urandom_range(0, 255));
        queue_frame(8'hFF, body, 1'b0, 1'b0);
        for (int i = 0; i < NBYTES; i++)
            body[i] = 8'($urandom_range(0, 255));
        queue_frame(8'h00, body, 1'b1, 1'b0);

        built = 0;
        est_results = 0;
        frames = 0;
        while (built < RAND_BYTES || est_results < 48) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int i = 0; i < NBYTES; i++)
                    body[i] = pick_data_byte();
                frames++;
                if ($urandom_range(0, 4) == 0) begin
                    queue_frame(8'($urandom_range(0, 255)), body, 1'b1, frames % 4 == 1);
                    est_results += 1;
                end else begin
                    queue_frame(8'($urandom_range(0, 255)), body, 1'b0, frames % 4 == 1);
                    est_results += PW;
                end
                built += NBYTES + 6;
            end else if (pick < 85) begin
                cut = $urandom_range(1, 6);
                for (int i = 0; i < cut; i++)
                    queue_byte(($urandom_range(0, 2) == 0) ? sfr_pkg::SYNC_A
                                                           : 8'($urandom_range(0, 255)));
                built += cut;
            end else if (pick < 95) begin
                queue_byte(sfr_pkg::SYNC_A);
                if ($urandom_range(0, 1) == 0) begin
                    queue_byte(not_byte(sfr_pkg::SYNC_B));
                    built += 2;
                end else begin
                    queue_byte(sfr_pkg::SYNC_B);
                    queue_byte(not_byte(sfr_pkg::SYNC_A));
                    built += 3;
                end
            end else begin
                // frame cut short; what follows is taken as its data
                cut = $urandom_range(0, NBYTES - 1);
                queue_byte(sfr_pkg::SYNC_A);
                queue_byte(sfr_pkg::SYNC_B);
                queue_byte(sfr_pkg::SYNC_A);
                queue_byte(8'($urandom_range(0, 255)));
                for (int i = 0; i < cut; i++)
                    queue_byte(pick_data_byte());
                built += cut + 4;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() != 0 || i_rx_valid)
            @(posedge i_clk);
        while (frame_words.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && frame_words.size() == 0)
            $display("tb_sync_frame_receiver_crc16: clean");
        else
            $display("tb_sync_frame_receiver_crc16: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_ctrl.sv
sv/sfr_datapath.sv
sv/sync_frame_receiver_crc16.sv
test/tb_sync_frame_receiver_crc16.sv
